// ===== design/udp_tx_cs_pkg.sv =====
// Package with the shared types, constants and helpers of the UDP transmit checksum generator.
`default_nettype none

package udp_tx_cs_pkg;

    // Frame limit that the total UDP length is checked against.
    localparam logic [16:0] MAX_FRAME      = 17'd1500;
    localparam logic [15:0] EPHEMERAL_BASE = 16'hC000;
    localparam logic [15:0] CKSUM_ALL_ONES = 16'hFFFF;
    localparam logic [15:0] PROTO_UDP      = 16'd17;
    localparam logic [16:0] UDP_HDR_BYTES  = 17'd8;

    // Configuration register indexes (word address bit 2 of paddr).
    localparam logic REG_LOCAL_IP = 1'b0;

    // One input request.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last;
        logic [31:0] dst_ip;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [15:0] payload_len;
        logic [15:0] time_ms;
    } udp_in_t;

    // One result request.
    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] chosen_src_port;
        logic [16:0] total_length;
        logic        too_long;
    } udp_out_t;

    // Item after the header stage: byte data plus the prepared header values.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last;
        logic [15:0] hdr_sum;
        logic [15:0] port;
        logic [16:0] seg_total;
    } hdr_item_t;

    // Ones' complement add of a 16-bit word with end-around carry.
    function automatic logic [15:0] add_fold(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

// ===== design/udp_tx_cs_hdr.sv =====
// Input register stage: samples a request and prepares the pseudo-header and header sum.
`default_nettype none

module udp_tx_cs_hdr
    import udp_tx_cs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [31:0] local_ip,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire udp_in_t     s_data,
    input  wire logic        take,
    output logic             item_valid,
    output hdr_item_t        item
);

    logic        item_valid_reg;
    logic        item_valid_next;
    hdr_item_t   item_reg;
    hdr_item_t   item_next;
    logic [15:0] port_sel;
    logic [16:0] seg_total;
    logic [19:0] raw_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // The register is free when empty or when the next stage takes its request.
    assign s_ready = !item_valid_reg || take;

    // Ephemeral port replaces a zero source port.
    assign port_sel  = (s_data.source_port != 16'd0) ? s_data.source_port
                                                     : (EPHEMERAL_BASE ^ s_data.time_ms);
    assign seg_total = UDP_HDR_BYTES + {1'b0, s_data.payload_len};

    // Plain sum of all header words, folded twice into a ones' complement value.
    always_comb begin
        raw_sum = {4'd0, local_ip[31:16]} + {4'd0, local_ip[15:0]}
                + {4'd0, s_data.dst_ip[31:16]} + {4'd0, s_data.dst_ip[15:0]}
                + {4'd0, PROTO_UDP} + {4'd0, seg_total[15:0]}
                + {4'd0, port_sel} + {4'd0, s_data.dest_port}
                + {4'd0, seg_total[15:0]};
        fold1 = {1'b0, raw_sum[15:0]} + {13'd0, raw_sum[19:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
    end

    // Next values of the stage register.
    always_comb begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (s_valid && s_ready) begin
            item_valid_next      = 1'b1;
            item_next.data_byte  = s_data.data_byte;
            item_next.byte_valid = s_data.byte_valid;
            item_next.last       = s_data.last;
            item_next.hdr_sum    = fold2;
            item_next.port       = port_sel;
            item_next.seg_total  = seg_total;
        end else if (take) begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== design/udp_tx_cs_acc.sv =====
// Accumulate stage: running payload sum, datagram state and the result register.
`default_nettype none

module udp_tx_cs_acc
    import udp_tx_cs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_valid,
    input  wire hdr_item_t item,
    output logic           take,
    output logic           m_valid,
    input  wire logic      m_ready,
    output udp_out_t       m_data
);

    logic [15:0] sum_acc_reg,     sum_acc_next;
    logic [7:0]  held_reg,        held_next;
    logic        pending_reg,     pending_next;
    logic        in_dgram_reg,    in_dgram_next;
    logic [16:0] seg_total_reg,   seg_total_next;
    logic [15:0] port_reg,        port_next;
    logic        m_valid_reg,     m_valid_next;
    udp_out_t    m_data_reg,      m_data_next;

    logic        start;
    logic [15:0] base_sum;
    logic [7:0]  held_cur;
    logic        pend_cur;
    logic [16:0] seg_cur;
    logic [15:0] port_cur;
    logic        add_en;
    logic [15:0] add_word;
    logic [15:0] sum_new;
    logic [15:0] ck;
    logic        too_long;

    // A request moves on when the result register is empty or being drained.
    assign take = item_valid && (!m_valid_reg || m_ready);

    // The first request of a datagram starts from the prepared header values.
    assign start    = !in_dgram_reg;
    assign base_sum = start ? item.hdr_sum   : sum_acc_reg;
    assign held_cur = start ? 8'd0           : held_reg;
    assign pend_cur = start ? 1'b0           : pending_reg;
    assign seg_cur  = start ? item.seg_total : seg_total_reg;
    assign port_cur = start ? item.port      : port_reg;

    // Pick the word, if any, that this request adds: a completed pair, or a padded odd byte at the end.
    always_comb begin
        add_en   = 1'b0;
        add_word = 16'd0;
        if (item.byte_valid && pend_cur) begin
            add_en   = 1'b1;
            add_word = {held_cur, item.data_byte};
        end else if (item.byte_valid && item.last) begin
            add_en   = 1'b1;
            add_word = {item.data_byte, 8'd0};
        end else if (!item.byte_valid && item.last && pend_cur) begin
            add_en   = 1'b1;
            add_word = {held_cur, 8'd0};
        end
    end

    assign sum_new = add_en ? add_fold(base_sum, add_word) : base_sum;

    // Final checksum: complement, zero sent as all ones, forced to zero when too long.
    always_comb begin
        too_long = seg_cur > MAX_FRAME;
        ck       = ~sum_new;
        if (ck == 16'd0) begin
            ck = CKSUM_ALL_ONES;
        end
        if (too_long) begin
            ck = 16'd0;
        end
    end

    // State and result updates.
    always_comb begin
        sum_acc_next   = sum_acc_reg;
        held_next      = held_reg;
        pending_next   = pending_reg;
        in_dgram_next  = in_dgram_reg;
        seg_total_next = seg_total_reg;
        port_next      = port_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (take) begin
            seg_total_next = seg_cur;
            port_next      = port_cur;
            if (item.last) begin
                sum_acc_next                = 16'd0;
                held_next                   = 8'd0;
                pending_next                = 1'b0;
                in_dgram_next               = 1'b0;
                m_valid_next                = 1'b1;
                m_data_next.checksum        = ck;
                m_data_next.chosen_src_port = port_cur;
                m_data_next.total_length    = seg_cur;
                m_data_next.too_long        = too_long;
            end else begin
                sum_acc_next  = sum_new;
                in_dgram_next = 1'b1;
                if (item.byte_valid && !pend_cur) begin
                    held_next    = item.data_byte;
                    pending_next = 1'b1;
                end else if (item.byte_valid) begin
                    held_next    = 8'd0;
                    pending_next = 1'b0;
                end else begin
                    held_next    = held_cur;
                    pending_next = pend_cur;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_acc_reg   <= 16'd0;
            held_reg      <= 8'd0;
            pending_reg   <= 1'b0;
            in_dgram_reg  <= 1'b0;
            seg_total_reg <= 17'd0;
            port_reg      <= 16'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            sum_acc_reg   <= sum_acc_next;
            held_reg      <= held_next;
            pending_reg   <= pending_next;
            in_dgram_reg  <= in_dgram_next;
            seg_total_reg <= seg_total_next;
            port_reg      <= port_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== design/udp_tx_checksum_generator_core.sv =====
// Top level of the UDP transmit checksum generator with its configuration port.
`default_nettype none

// Streams datagram payload bytes and returns one result per datagram on the request
// marked last: the UDP checksum over the IPv4 pseudo-header, the header and the
// payload, the source port used (an ephemeral port built from time_ms when the
// requested source port is zero), the total UDP length and a too-long flag. The header
// fields are sampled on the first request of a datagram. A request passes an input
// register stage and an accumulate stage, which writes the result register when it
// takes the last request; the block sustains one request per cycle while m_ready does
// not stall it. Back-pressure on m_ready reaches s_ready in the same cycle. local_ip
// lives at byte address 0 and must be written only while no datagram is in progress.
module udp_tx_checksum_generator_core
    import udp_tx_cs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire udp_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output udp_out_t         m_data
);

    logic [31:0] local_ip_reg;
    logic [31:0] local_ip_next;
    logic        take;
    logic        item_valid;
    hdr_item_t   item;
    logic        reg_sel;

    // Configuration register write and read-back.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb begin
        local_ip_next = local_ip_reg;
        if (psel && penable && pwrite && (reg_sel == REG_LOCAL_IP)) begin
            local_ip_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg <= 32'd0;
        end else begin
            local_ip_reg <= local_ip_next;
        end
    end

    assign prdata = (reg_sel == REG_LOCAL_IP) ? local_ip_reg : 32'd0;

    // Input register and header preparation.
    udp_tx_cs_hdr u_hdr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .local_ip   (local_ip_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Payload accumulation and result register.
    udp_tx_cs_acc u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
